>>> rtl/core/tos_pkg.sv
// Shared types and constants for the TCP option scanner.
package tos_pkg;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 120;

  localparam logic [5:0] POS_MAX    = 6'd63;
  localparam logic [5:0] DOFF_POS   = 6'd12;
  localparam logic [5:0] OPT_START  = 6'd20;
  localparam logic [5:0] SHORT_HDR  = 6'd33;
  localparam logic [5:0] TS_MIN_HDR = 6'd30;

  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;
  localparam logic [7:0] MIN_OPT_LEN = 8'd2;

  localparam logic [5:0] OFF_SCALE    = 6'd2;
  localparam logic [5:0] OFF_TSV_LO   = 6'd2;
  localparam logic [5:0] OFF_TSV_HI   = 6'd5;
  localparam logic [5:0] OFF_TSE_LO   = 6'd6;
  localparam logic [5:0] OFF_TSE_HI   = 6'd9;

  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  // One classified header byte on its way from the front to the walker.
  typedef struct packed {
    logic [7:0]  hdr_byte;
    logic        last;
    logic [31:0] now_us;
    logic [5:0]  pos;
    logic [5:0]  hlen;
    logic        walk_en;
    logic        truncated;
  } tos_item_t;

  typedef struct packed {
    logic [5:0]  header_bytes;
    logic [7:0]  window_scale;
    logic        scale_found;
    logic        timestamp_found;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic [31:0] rtt_sample;
    logic        malformed;
  } tos_result_t;

endpackage

>>> rtl/core/tos_front.sv
// Front end: counts header bytes, takes the data offset and classifies each item.
module tos_front import tos_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  hdr_byte,
  input  logic        last_byte,
  input  logic [31:0] now_us,
  output tos_item_t   item
);

  logic [5:0] pos_r, pos_nxt;
  logic [5:0] hlen_r, hlen_nxt;
  logic [5:0] hlen_cur;
  logic [5:0] pos_inc;

  always_comb begin
    hlen_cur = (pos_r == DOFF_POS) ? {hdr_byte[7:4], 2'b00} : hlen_r;
    pos_inc  = (pos_r == POS_MAX) ? POS_MAX : pos_r + 6'd1;

    item.hdr_byte  = hdr_byte;
    item.last      = last_byte;
    item.now_us    = now_us;
    item.pos       = pos_r;
    item.hlen      = hlen_cur;
    item.walk_en   = (pos_r >= OPT_START) && (pos_r < hlen_cur);
    item.truncated = (pos_inc <= DOFF_POS) || (pos_inc < hlen_cur);

    pos_nxt  = pos_r;
    hlen_nxt = hlen_r;
    if (accept) begin
      if (last_byte) begin
        pos_nxt  = '0;
        hlen_nxt = '0;
      end else begin
        pos_nxt  = pos_inc;
        hlen_nxt = hlen_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hlen_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      hlen_r <= hlen_nxt;
    end
  end

endmodule

>>> rtl/core/tos_queue.sv
// Two-entry queue between the byte classifier and the option walker.
module tos_queue import tos_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tos_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output tos_item_t pop_item
);

  tos_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("pop from an empty queue");
  a_ptr_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) == (count_r == 2'd0 || count_r == 2'd2))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/tos_back.sv
// Back end: walks the TCP options and registers one summary item per header.
module tos_back import tos_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tos_item_t          q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [5:0]  next_at_r, next_at_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [5:0]  start_r, start_nxt;
  logic [7:0]  scale_r, scale_nxt;
  logic        scale_seen_r, scale_seen_nxt;
  logic        stamp_seen_r, stamp_seen_nxt;
  logic [31:0] stamp_val_r, stamp_val_nxt;
  logic [31:0] stamp_echo_r, stamp_echo_nxt;
  logic        bad_len_r, bad_len_nxt;

  logic        out_valid_r;
  tos_result_t res_r, res_nxt;

  logic [5:0]  pos_inc;
  logic [8:0]  opt_end;
  logic [5:0]  off;
  logic        ts_ok;

  assign q_pop = q_valid && (!q_item.last || !out_valid_r || out_tready);

  always_comb begin
    pos_inc   = (q_item.pos == POS_MAX) ? POS_MAX : q_item.pos + 6'd1;
    opt_end   = {3'b000, start_r} + {1'b0, q_item.hdr_byte};
    off       = q_item.pos - start_r;
    phase_eff = (phase_r == PH_BODY && q_item.pos >= next_at_r) ? PH_KIND : phase_r;

    phase_nxt      = phase_r;
    next_at_nxt    = next_at_r;
    kind_nxt       = kind_r;
    start_nxt      = start_r;
    scale_nxt      = scale_r;
    scale_seen_nxt = scale_seen_r;
    stamp_seen_nxt = stamp_seen_r;
    stamp_val_nxt  = stamp_val_r;
    stamp_echo_nxt = stamp_echo_r;
    bad_len_nxt    = bad_len_r;

    if (q_pop && q_item.walk_en && phase_r != PH_STOP) begin
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_KIND: begin
          if (q_item.hdr_byte == KIND_NOP) begin
            next_at_nxt = pos_inc;
          end else if (q_item.hdr_byte == KIND_EOL) begin
            phase_nxt = PH_STOP;
          end else begin
            kind_nxt  = q_item.hdr_byte;
            start_nxt = q_item.pos;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (q_item.hdr_byte < MIN_OPT_LEN) begin
            bad_len_nxt = 1'b1;
            phase_nxt   = PH_STOP;
          end else begin
            next_at_nxt = (opt_end > {3'b000, POS_MAX}) ? POS_MAX : opt_end[5:0];
            phase_nxt   = PH_BODY;
          end
        end
        PH_BODY: begin
          if (kind_r == KIND_WSCALE && !scale_seen_r && off == OFF_SCALE) begin
            scale_nxt      = q_item.hdr_byte;
            scale_seen_nxt = 1'b1;
          end else if (kind_r == KIND_TSTAMP && !stamp_seen_r) begin
            if (off >= OFF_TSV_LO && off <= OFF_TSV_HI) begin
              stamp_val_nxt = {stamp_val_r[23:0], q_item.hdr_byte};
            end else if (off >= OFF_TSE_LO && off <= OFF_TSE_HI) begin
              stamp_echo_nxt = {stamp_echo_r[23:0], q_item.hdr_byte};
            end
            if (off == OFF_TSE_HI) begin
              stamp_seen_nxt = 1'b1;
            end
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
    end

    // The summary is taken from the state as it stands after this byte.
    ts_ok = stamp_seen_nxt && (q_item.hlen >= TS_MIN_HDR);
    res_nxt.header_bytes    = q_item.hlen;
    res_nxt.window_scale    = (q_item.hlen < SHORT_HDR) ? 8'd1 :
                              (scale_seen_nxt ? scale_nxt : 8'd0);
    res_nxt.scale_found     = scale_seen_nxt;
    res_nxt.timestamp_found = ts_ok;
    res_nxt.ts_value        = ts_ok ? stamp_val_nxt : 32'd0;
    res_nxt.ts_echo         = ts_ok ? stamp_echo_nxt : 32'd0;
    res_nxt.rtt_sample      = ts_ok ? (q_item.now_us - stamp_echo_nxt) : 32'd0;
    res_nxt.malformed       = bad_len_nxt || q_item.truncated;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && q_item.last)) begin
      phase_r      <= PH_KIND;
      next_at_r    <= OPT_START;
      kind_r       <= '0;
      start_r      <= '0;
      scale_r      <= '0;
      scale_seen_r <= 1'b0;
      stamp_seen_r <= 1'b0;
      stamp_val_r  <= '0;
      stamp_echo_r <= '0;
      bad_len_r    <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      next_at_r    <= next_at_nxt;
      kind_r       <= kind_nxt;
      start_r      <= start_nxt;
      scale_r      <= scale_nxt;
      scale_seen_r <= scale_seen_nxt;
      stamp_seen_r <= stamp_seen_nxt;
      stamp_val_r  <= stamp_val_nxt;
      stamp_echo_r <= stamp_echo_nxt;
      bad_len_r    <= bad_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.malformed, res_r.rtt_sample, res_r.ts_echo,
                       res_r.ts_value, res_r.timestamp_found, res_r.scale_found,
                       res_r.window_scale, res_r.header_bytes};

`ifndef SYNTHESIS
  a_rtt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.timestamp_found |-> res_r.rtt_sample == 32'd0)
    else $error("rtt reported without a timestamp");
  a_short_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.header_bytes < SHORT_HDR |-> res_r.window_scale == 8'd1)
    else $error("short header must report a scale of one");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r)
    else $error("result dropped while stalled");
`endif

endmodule

>>> rtl/core/tcp_option_scanner.sv
// A header's last byte goes through the queue and then the result register, which raises
// out_tvalid with its summary item; it waits in the queue while an earlier one is stalled.
// Throughput: one header byte per cycle unless stalled; a two-entry queue parts the byte
// classifier from the option walker, and a registered result slot lets bytes flow on.
// Reset: synchronous, active low; clears the position counters, walk state and queue.
// Top level of the TCP option scanner.
module tcp_option_scanner import tos_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [7:0] hdr_byte, [39:8] now_us
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [5:0] header_bytes, [13:6] window_scale,
                                       // [14] scale_found, [15] timestamp_found,
                                       // [47:16] ts_value, [79:48] ts_echo,
                                       // [111:80] rtt_sample, [112] malformed
);

  tos_item_t front_item;
  tos_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  tos_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .hdr_byte  (in_tdata[7:0]),
    .last_byte (in_tlast),
    .now_us    (in_tdata[39:8]),
    .item      (front_item)
  );

  tos_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  tos_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/tcp_option_scanner_tb.sv
// Self-checking testbench for the TCP option scanner: directed headers, then random ones.
`timescale 1ns / 1ps

module tcp_option_scanner_tb;
  import tos_pkg::*;

  localparam int unsigned DIR_ROWS       = 41;
  localparam int unsigned RAND_ITEMS     = 580;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Summaries that can be read straight off the header bytes.
  localparam tos_result_t SUM_ONE_BYTE  = '{window_scale: 8'd1, malformed: 1'b1, default: '0};
  localparam tos_result_t SUM_SHORT_OFF =
    '{header_bytes: 6'd16, window_scale: 8'd1, malformed: 1'b1, default: '0};
  localparam tos_result_t SUM_BAD_LEN   =
    '{header_bytes: 6'd24, window_scale: 8'd1, malformed: 1'b1, default: '0};

  typedef struct {
    int unsigned reps;
    logic [7:0]  hdr_byte;
    logic        last;
    logic [31:0] now_us;
    logic        typed;
    tos_result_t summary;
  } hdr_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // [7:0] hdr_byte, [39:8] now_us
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // [5:0] header_bytes, [13:6] window_scale,
                                // [14] scale_found, [15] timestamp_found,
                                // [47:16] ts_value, [79:48] ts_echo,
                                // [111:80] rtt_sample, [112] malformed

  tos_result_t summary_q[$];
  logic [7:0]  pkt_q[$];
  int unsigned n_mismatch    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned tx_fast_left  = 0;
  int unsigned rx_fast_left  = 0;
  bit          tx_burst      = 1'b0;
  bit          rx_hold_req   = 1'b0;

  // Scanner state as the predictor sees it.
  logic [5:0]  sc_pos;
  logic [5:0]  sc_hlen;
  logic [5:0]  sc_next_opt;
  logic [5:0]  sc_opt_start;
  phase_t      sc_phase;
  logic [7:0]  sc_kind;
  logic [7:0]  sc_scale;
  logic        sc_scale_seen;
  logic        sc_stamp_seen;
  logic [31:0] sc_tsval;
  logic [31:0] sc_tsecr;
  logic        sc_bad_len;

  hdr_row_t dir_rows [DIR_ROWS] = '{
    // A lone byte marked last: nothing known, truncated.
    '{1,  8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, SUM_ONE_BYTE},
    // Data offset below five and the header cut off just after byte 12.
    '{12, 8'h00, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h40, 1'b1, 32'd0, 1'b1, SUM_SHORT_OFF},
    // Forty-byte header: NOP, window scale, timestamp, repeated scale, unknown, end of list.
    '{12, 8'h00, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'hA0, 1'b0, 32'd0, 1'b0, '0},
    '{7,  8'h00, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_NOP, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_WSCALE, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h03, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h0E, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_TSTAMP, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h0A, 1'b0, 32'd0, 1'b0, '0},
    '{4,  8'hFF, 1'b0, 32'd0, 1'b0, '0},
    '{4,  8'h01, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_WSCALE, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h03, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h07, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'hFF, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h02, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_EOL, 1'b1, 32'd0, 1'b0, '0},
    // Option length below two stops the walk.
    '{12, 8'h5A, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h60, 1'b0, 32'd0, 1'b0, '0},
    '{7,  8'h5A, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h22, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h01, 1'b0, 32'd0, 1'b0, '0},
    '{2,  KIND_WSCALE, 1'b1, 32'h8000_0000, 1'b1, SUM_BAD_LEN},
    // Options too short for their fields, a timestamp cut by the header end, then payload.
    '{12, 8'h00, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h80, 1'b0, 32'd0, 1'b0, '0},
    '{7,  8'h00, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_TSTAMP, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h04, 1'b0, 32'd0, 1'b0, '0},
    '{2,  8'h11, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_WSCALE, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h02, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_WSCALE, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h03, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h09, 1'b0, 32'd0, 1'b0, '0},
    '{1,  KIND_TSTAMP, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'h0A, 1'b0, 32'd0, 1'b0, '0},
    '{1,  8'hAB, 1'b0, 32'd0, 1'b0, '0},
    '{4,  8'hEE, 1'b1, 32'h1234_5678, 1'b0, '0}
  };

  tcp_option_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [5:0] clamp_pos(int unsigned v);
    return (v > POS_MAX) ? POS_MAX : v[5:0];
  endfunction

  task automatic clear_scan();
    sc_pos        = '0;
    sc_hlen       = '0;
    sc_next_opt   = OPT_START;
    sc_opt_start  = '0;
    sc_phase      = PH_KIND;
    sc_kind       = '0;
    sc_scale      = '0;
    sc_scale_seen = 1'b0;
    sc_stamp_seen = 1'b0;
    sc_tsval      = '0;
    sc_tsecr      = '0;
    sc_bad_len    = 1'b0;
  endtask

  task automatic walk_option_byte(input logic [5:0] pos, input logic [7:0] b);
    int off;
    if (sc_phase == PH_BODY && pos >= sc_next_opt) sc_phase = PH_KIND;
    case (sc_phase)
      PH_KIND: begin
        if (b == KIND_NOP) begin
          sc_next_opt = clamp_pos(32'(pos) + 32'd1);
        end else if (b == KIND_EOL) begin
          sc_phase = PH_STOP;
        end else begin
          sc_kind      = b;
          sc_opt_start = pos;
          sc_phase     = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < MIN_OPT_LEN) begin
          sc_bad_len = 1'b1;
          sc_phase   = PH_STOP;
        end else begin
          sc_next_opt = clamp_pos(32'(sc_opt_start) + 32'(b));
          sc_phase    = PH_BODY;
        end
      end
      PH_BODY: begin
        off = int'(pos) - int'(sc_opt_start);
        if (sc_kind == KIND_WSCALE && !sc_scale_seen && off == int'(OFF_SCALE)) begin
          sc_scale      = b;
          sc_scale_seen = 1'b1;
        end else if (sc_kind == KIND_TSTAMP && !sc_stamp_seen) begin
          if (off >= int'(OFF_TSV_LO) && off <= int'(OFF_TSV_HI))
            sc_tsval = {sc_tsval[23:0], b};
          else if (off >= int'(OFF_TSE_LO) && off <= int'(OFF_TSE_HI))
            sc_tsecr = {sc_tsecr[23:0], b};
          if (off == int'(OFF_TSE_HI)) sc_stamp_seen = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_summary(input logic [7:0] b, input logic last, input logic [31:0] now,
                                 output logic has_sum, output tos_result_t sum);
    logic [5:0] pos;
    logic       trunc;
    logic       ts_ok;
    pos = sc_pos;
    if (pos == DOFF_POS) sc_hlen = {b[7:4], 2'b00};
    if (pos >= OPT_START && pos < sc_hlen && sc_phase != PH_STOP) walk_option_byte(pos, b);
    sc_pos  = clamp_pos(32'(pos) + 32'd1);
    has_sum = last;
    sum     = '0;
    if (last) begin
      trunc = (sc_pos <= DOFF_POS) || (sc_pos < sc_hlen);
      ts_ok = sc_stamp_seen && (sc_hlen >= TS_MIN_HDR);
      sum.header_bytes    = sc_hlen;
      sum.window_scale    = (sc_hlen < SHORT_HDR) ? 8'd1 : (sc_scale_seen ? sc_scale : 8'd0);
      sum.scale_found     = sc_scale_seen;
      sum.timestamp_found = ts_ok;
      sum.ts_value        = ts_ok ? sc_tsval : 32'd0;
      sum.ts_echo         = ts_ok ? sc_tsecr : 32'd0;
      sum.rtt_sample      = ts_ok ? (now - sc_tsecr) : 32'd0;
      sum.malformed       = sc_bad_len || trunc;
      clear_scan();
    end
  endtask

  // Offers one header byte after a random gap; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] now,
                           input logic typed, input tos_result_t typed_sum);
    int unsigned gap;
    logic        has_sum;
    tos_result_t sum;
    if (tx_burst) begin
      gap = 0;
    end else if (tx_fast_left > 0) begin
      gap = 0;
      tx_fast_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) tx_fast_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_summary(b, last, now, has_sum, sum);
    if (has_sum) summary_q.push_back(typed ? typed_sum : sum);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS)
        $display("Mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : summary_check
    tos_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (summary_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("Summary item 0x%0h arrived with none expected", out_tdata);
      end else begin
        want = summary_q.pop_front();
        check_field("header_bytes", 32'(want.header_bytes), 32'(out_tdata[5:0]));
        check_field("window_scale", 32'(want.window_scale), 32'(out_tdata[13:6]));
        check_field("scale_found", 32'(want.scale_found), 32'(out_tdata[14]));
        check_field("timestamp_found", 32'(want.timestamp_found), 32'(out_tdata[15]));
        check_field("ts_value", want.ts_value, out_tdata[47:16]);
        check_field("ts_echo", want.ts_echo, out_tdata[79:48]);
        check_field("rtt_sample", want.rtt_sample, out_tdata[111:80]);
        check_field("malformed", 32'(want.malformed), 32'(out_tdata[112]));
      end
    end
  end

  // Receiver: a random wait before each summary item, or a long hold when asked for.
  initial begin : summary_sink
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        gap         = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else if (rx_fast_left > 0) begin
        gap = 0;
        rx_fast_left--;
      end else begin
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0) rx_fast_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin : header_source
    int unsigned row;
    int unsigned rep;
    int unsigned j;
    int unsigned n_rand_items;
    int unsigned n_pkts;
    int unsigned doff;
    int unsigned hlen;
    int unsigned plen;
    int unsigned olen;
    int unsigned pick;
    bit          pressure_done;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    n_rand_items  = 0;
    n_pkts        = 0;
    pressure_done = 1'b0;
    clear_scan();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < DIR_ROWS; row++) begin
      for (rep = 0; rep < dir_rows[row].reps; rep++) begin
        send_byte(dir_rows[row].hdr_byte, dir_rows[row].last && (rep == dir_rows[row].reps - 1),
                  dir_rows[row].now_us, dir_rows[row].typed && (rep == dir_rows[row].reps - 1),
                  dir_rows[row].summary);
      end
    end

    while (n_rand_items < RAND_ITEMS) begin
      if (!pressure_done && n_pkts == 4) begin
        // One-byte headers back to back while the sink holds off, so the block backs up.
        pressure_done = 1'b1;
        rx_hold_req   = 1'b1;
        tx_burst      = 1'b1;
        repeat (12) begin
          send_byte(8'($urandom), 1'b1, $urandom, 1'b0, '0);
          n_rand_items++;
        end
        tx_burst = 1'b0;
        in_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(negedge clk);
      end

      pkt_q.delete();
      if ($urandom_range(0, 99) < 12) begin
        plen = $urandom_range(1, 24);
        repeat (plen) pkt_q.push_back(8'($urandom));
      end else begin
        doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        hlen = doff * 4;
        repeat (12) pkt_q.push_back(8'($urandom));
        pkt_q.push_back({doff[3:0], 4'($urandom)});
        repeat (7) pkt_q.push_back(8'($urandom));
        while (pkt_q.size() < hlen) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            pkt_q.push_back(KIND_NOP);
          end else if (pick < 20) begin
            pkt_q.push_back(KIND_EOL);
          end else if (pick < 40) begin
            olen = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) : 3;
            pkt_q.push_back(KIND_WSCALE);
            pkt_q.push_back(8'(olen));
            repeat (olen - 2) pkt_q.push_back(8'($urandom));
          end else if (pick < 65) begin
            olen = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 12) : 10;
            pkt_q.push_back(KIND_TSTAMP);
            pkt_q.push_back(8'(olen));
            repeat (olen - 2) pkt_q.push_back(8'($urandom));
          end else if (pick < 92) begin
            olen = $urandom_range(2, 10);
            pkt_q.push_back(8'($urandom_range(2, 255)));
            pkt_q.push_back(8'(olen));
            repeat (olen - 2) pkt_q.push_back(8'($urandom));
          end else begin
            pkt_q.push_back(8'($urandom_range(2, 255)));
            pkt_q.push_back(8'($urandom_range(0, 1)));
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 65)
          plen = hlen;
        else if (pick < 78)
          plen = $urandom_range(1, (hlen > 13) ? hlen - 1 : 12);
        else if (pick < 96)
          plen = hlen + $urandom_range(1, 10);
        else
          plen = $urandom_range(64, 80);
        if (plen == 0) plen = 1;
        while (pkt_q.size() < plen) pkt_q.push_back(8'($urandom));
        while (pkt_q.size() > plen) void'(pkt_q.pop_back());
      end

      for (j = 0; j < pkt_q.size(); j++) begin
        send_byte(pkt_q[j], j == pkt_q.size() - 1, $urandom, 1'b0, '0);
        n_rand_items++;
      end
      n_pkts++;
    end

    in_tvalid <= 1'b0;
    while (summary_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (n_mismatch == 0 && summary_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
